@@ rtl/mpc_pkg.sv @@
// mpc_pkg: shared word types, verdict codes and signature constants
// for the MGCP payload classifier. No dependencies.
`default_nettype none
package mpc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WIN_BYTES = 5;
  localparam int unsigned WIN_W     = WIN_BYTES * BYTE_W;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned NUM_VERBS = 9;

  // verdict codes
  localparam logic [2:0] REASON_MATCH  = 3'd0;
  localparam logic [2:0] REASON_SHORT  = 3'd1;
  localparam logic [2:0] REASON_ENDING = 3'd2;
  localparam logic [2:0] REASON_VERB   = 3'd3;
  localparam logic [2:0] REASON_TOKEN  = 3'd4;

  localparam logic [BYTE_W-1:0] LINE_FEED = 8'h0a;

  // offsets that gate the tests
  localparam logic [CNT_W-1:0] VERB_IDX     = 16'd4;
  localparam logic [CNT_W-1:0] MIN_LAST_IDX = 16'd7;
  localparam logic [CNT_W-1:0] TOKEN_IDX    = 16'd8;

  localparam logic [WIN_W-1:0] TOKEN_WORD = "MGCP ";

  localparam logic [WIN_W-1:0] VERB_TABLE [NUM_VERBS] = '{
    "AUEP ", "AUCX ", "CRCX ", "DLCX ", "EPCF ",
    "MDCX ", "NTFY ", "RQNT ", "RSIP "
  };

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    logic              truncated;
  } in_word_t;

  typedef struct packed {
    logic       is_mgcp;
    logic [2:0] reason;
  } out_word_t;

  // shift control handed to every cell of the byte window
  typedef struct packed {
    logic en;
    logic clr;
  } shift_ctl_t;

  function automatic logic is_verb(input logic [WIN_W-1:0] w);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_VERBS; i++) begin
      hit = hit | (VERB_TABLE[i] == w);
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

@@ rtl/mpc_cell.sv @@
// mpc_cell: one byte stage of the payload window chain.
// Depends on mpc_pkg.
`default_nettype none
module mpc_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire mpc_pkg::shift_ctl_t        ctl,
  input  wire logic [mpc_pkg::BYTE_W-1:0] byte_in,
  output logic      [mpc_pkg::BYTE_W-1:0] byte_out
);

  logic [mpc_pkg::BYTE_W-1:0] byte_r;
  logic [mpc_pkg::BYTE_W-1:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.en) begin
      byte_nxt = ctl.clr ? '0 : byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_out = byte_r;

endmodule
`default_nettype wire

@@ rtl/mpc_verdict.sv @@
// mpc_verdict: byte counter, verb/token flags and the registered verdict word.
// Depends on mpc_pkg; window comes from the mpc_cell chain.
`default_nettype none
module mpc_verdict (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire mpc_pkg::in_word_t         in_word,
  input  wire logic                      in_take,
  input  wire logic [mpc_pkg::WIN_W-1:0] window,
  output logic                           in_stall,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output mpc_pkg::out_word_t             out_word
);

  logic [mpc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      verb_r, verb_nxt;
  logic                      token_r, token_nxt;
  logic                      out_valid_r, out_valid_nxt;
  mpc_pkg::out_word_t        out_word_r, out_word_nxt;

  logic       verb_hit;
  logic       token_hit;
  logic [2:0] reason;

  assign verb_hit  = (cnt_r == mpc_pkg::VERB_IDX) && mpc_pkg::is_verb(window);
  assign token_hit = (cnt_r >= mpc_pkg::TOKEN_IDX) && (window == mpc_pkg::TOKEN_WORD);

  always_comb begin
    if (cnt_r < mpc_pkg::MIN_LAST_IDX) begin
      reason = mpc_pkg::REASON_SHORT;
    end else if (!in_word.truncated && in_word.data_byte != mpc_pkg::LINE_FEED) begin
      reason = mpc_pkg::REASON_ENDING;
    end else if (!(verb_r || verb_hit)) begin
      reason = mpc_pkg::REASON_VERB;
    end else if (!token_r) begin
      // a token ending on the final byte does not count
      reason = mpc_pkg::REASON_TOKEN;
    end else begin
      reason = mpc_pkg::REASON_MATCH;
    end
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    verb_nxt      = verb_r;
    token_nxt     = token_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    if (in_take) begin
      if (in_word.last_byte) begin
        cnt_nxt              = '0;
        verb_nxt             = 1'b0;
        token_nxt            = 1'b0;
        out_valid_nxt        = 1'b1;
        out_word_nxt.is_mgcp = (reason == mpc_pkg::REASON_MATCH);
        out_word_nxt.reason  = reason;
      end else begin
        cnt_nxt   = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
        verb_nxt  = verb_r || verb_hit;
        token_nxt = token_r || token_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      verb_r      <= 1'b0;
      token_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      verb_r      <= verb_nxt;
      token_r     <= token_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  // a held verdict stalls every input word until it is released
  assign in_stall  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_match_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.is_mgcp == (out_word_r.reason == mpc_pkg::REASON_MATCH)))
    else $error("is_mgcp disagrees with reason");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_word.last_byte) |=> (cnt_r == '0 && !verb_r && !token_r))
    else $error("packet state not cleared after last word");

  a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && !in_word.last_byte && cnt_r == '1) |=> (cnt_r == '1))
    else $error("byte counter wrapped");

  a_token_late: assert property (@(posedge clk) disable iff (!rst_n)
    token_r |-> (cnt_r > mpc_pkg::TOKEN_IDX))
    else $error("token flag set too early");

  a_verb_late: assert property (@(posedge clk) disable iff (!rst_n)
    verb_r |-> (cnt_r > mpc_pkg::VERB_IDX))
    else $error("verb flag set too early");

endmodule
`default_nettype wire

@@ rtl/mgcp_payload_classifier.sv @@
// MGCP payload classifier: one payload byte per cycle, verdict on the last byte.
// The verdict word is registered and valid in the cycle after the last byte is accepted.
// Throughput: one byte per cycle; input stalls only while a verdict is held.
// The window is a chain of four byte cells plus the live input byte.
// Reset (rst_n low, synchronous) clears the counter, flags, cells and output valid; the verdict word is not reset.
// Depends on mpc_pkg, mpc_cell, mpc_verdict.
`default_nettype none
module mgcp_payload_classifier (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mpc_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mpc_pkg::out_word_t      out_word
);

  localparam int unsigned NUM_CELLS = mpc_pkg::WIN_BYTES - 1;

  logic                         in_take;
  mpc_pkg::shift_ctl_t          ctl;
  logic [mpc_pkg::BYTE_W-1:0]   tap [NUM_CELLS+1];
  logic [mpc_pkg::WIN_W-1:0]    window;

  assign in_take = in_valid && !in_stall;
  assign ctl.en  = in_take;
  assign ctl.clr = in_word.last_byte;
  assign tap[0]  = in_word.data_byte;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    mpc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .byte_in  (tap[k]),
      .byte_out (tap[k+1])
    );
    // oldest byte lands in the high end of the window
    assign window[(k+1)*mpc_pkg::BYTE_W +: mpc_pkg::BYTE_W] = tap[k+1];
  end

  assign window[0 +: mpc_pkg::BYTE_W] = tap[0];

  mpc_verdict u_verdict (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .in_take   (in_take),
    .window    (window),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire
